### src/pgb_pkg.sv
// Shared types and constants of the subpath bounding-box grouper.
`default_nettype none

package pgb_pkg;

  // Word offsets wrap at 2^IndexBits; coordinates are Q16.16.
  localparam int IndexBits    = 16;
  localparam int FractionBits = 16;
  localparam int CoordW       = 32;
  localparam int LenW         = IndexBits + 1;

  // Result field widths.
  localparam int StartW    = 16;
  localparam int LengthW   = 17;
  localparam int SubpathsW = 16;
  localparam int LimitW    = 16;

  localparam logic [LimitW-1:0] GroupLimitReset = 16'd960;

  localparam logic [CoordW-1:0] FracMask = CoordW'((64'd1 << FractionBits) - 64'd1);

  // Command codes in the integer part of a word.
  localparam int CmdMove   = 0;
  localparam int CmdClose  = 1;
  localparam int CmdLine   = 2;
  localparam int CmdBezier = 3;

  // Coordinates owed by a command.
  localparam logic [2:0] CoordsPoint  = 3'd2;
  localparam logic [2:0] CoordsBezier = 3'd6;

  // Configuration port.
  localparam int   ApbAddrW      = 3;
  localparam int   ApbDataW      = 32;
  localparam logic RegGroupLimit = 1'b0;

  // Result queue.
  localparam int ResultDepth = 4;
  localparam int QPtrW       = $clog2(ResultDepth);
  localparam int QCntW       = QPtrW + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [IndexBits-1:0]     pos_t;
  typedef logic [LenW-1:0]          len_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  typedef enum logic [1:0] {
    ReasonDisjoint = 2'd0,
    ReasonLimit    = 2'd1,
    ReasonEnd      = 2'd2
  } reason_e;

  typedef struct packed {
    logic [StartW-1:0]    group_start;
    logic [LengthW-1:0]   group_length;
    logic [SubpathsW-1:0] group_subpaths;
    reason_e              flush_reason;
    logic                 last_in_run;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_slot_t;

endpackage

`default_nettype wire

### src/pgb_in_if.sv
// Path word channel: valid/ready with one path word per transfer.
`default_nettype none

interface pgb_in_if;
  logic                  valid;
  logic                  ready;
  pgb_pkg::coord_t       path_word;
  logic                  last_word;

  modport source (output valid, output path_word, output last_word, input ready);
  modport sink   (input valid, input path_word, input last_word, output ready);
endinterface

`default_nettype wire

### src/pgb_out_if.sv
// Group result channel: valid/ready with one emitted group per transfer.
`default_nettype none

interface pgb_out_if;
  logic                             valid;
  logic                             ready;
  logic [pgb_pkg::StartW-1:0]       group_start;
  logic [pgb_pkg::LengthW-1:0]      group_length;
  logic [pgb_pkg::SubpathsW-1:0]    group_subpaths;
  logic [1:0]                       flush_reason;
  logic                             last_in_run;

  modport source (output valid, output group_start, output group_length,
                  output group_subpaths, output flush_reason, output last_in_run,
                  input ready);
  modport sink   (input valid, input group_start, input group_length,
                  input group_subpaths, input flush_reason, input last_in_run,
                  output ready);
endinterface

`default_nettype wire

### src/pgb_result_fifo.sv
// Small result queue that takes up to two results per cycle and gives one.
`default_nettype none

module pgb_result_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pgb_pkg::result_slot_t [1:0]          slots_i,
  output logic                                 space_o,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output pgb_pkg::result_t                     result_o
);

  pgb_pkg::result_t                 mem_q [pgb_pkg::ResultDepth];
  logic [pgb_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [pgb_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [pgb_pkg::QCntW-1:0]        count_q, count_d;
  logic [pgb_pkg::QPtrW-1:0]        wr_ptr_next;
  logic                             pop;
  logic [pgb_pkg::QCntW-1:0]        n_push;

  assign pop         = valid_o && ready_i;
  assign valid_o     = (count_q != '0);
  assign result_o    = mem_q[rd_ptr_q];
  assign space_o     = (count_q <= pgb_pkg::QCntW'(pgb_pkg::ResultDepth - 2));
  assign wr_ptr_next = wr_ptr_q + pgb_pkg::QPtrW'(1);
  assign n_push      = pgb_pkg::QCntW'(slots_i[0].valid) + pgb_pkg::QCntW'(slots_i[1].valid);

  always_comb begin
    wr_ptr_d = wr_ptr_q + pgb_pkg::QPtrW'(n_push);
    rd_ptr_d = pop ? rd_ptr_q + pgb_pkg::QPtrW'(1) : rd_ptr_q;
    count_d  = count_q + n_push - pgb_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    if (slots_i[0].valid) begin
      mem_q[wr_ptr_q] <= slots_i[0].data;
    end
    if (slots_i[1].valid) begin
      mem_q[wr_ptr_next] <= slots_i[1].data;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_i[0].valid |-> space_o)
    else $error("result pushed without room");

  a_slot_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_i[1].valid |-> slots_i[0].valid)
    else $error("second result slot used without the first");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pgb_pkg::QCntW'(pgb_pkg::ResultDepth))
    else $error("result queue count out of range");

endmodule

`default_nettype wire

### src/path_subpath_bbox_grouper_core.sv
// Top level of the subpath bounding-box grouper.
`default_nettype none

// Streams a vector path one 32-bit word per transfer and emits one result per
// group of overlapping subpaths. A word is a Q16.16 coordinate or a command
// (integer part 0 move, 1 close, 2 line, 3 bezier); words ahead of the first
// move are skipped. Each subpath's inclusive box is merged into the current
// group when the boxes touch and the word total stays within group_word_limit
// (APB register 0, reset 960); otherwise the group is emitted and a new one
// starts. The word flagged last_word closes the path, flushes the final group
// and returns all path state to reset, so the next word starts a new path at
// offset zero. Throughput is one word per cycle while the result queue has room: a
// word is held in the input register, is resolved in one pass of compare-and-select
// logic, and its results (zero, one or two) land in a four-entry result queue whose
// head drives the output, so results pass both the input register and the queue.
// The input side stalls only while the queue holds more than two results, as
// one word may produce two; a stalled output therefore stops input after the
// queue fills. last_in_run marks the final result caused by a word.
module path_subpath_bbox_grouper_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pgb_in_if.sink                          path_i,
  pgb_out_if.source                       group_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pgb_pkg::ApbAddrW-1:0]    paddr,
  input  logic [pgb_pkg::ApbDataW-1:0]    pwdata,
  output logic [pgb_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  // ---------------------------------------------------------------- config
  logic [pgb_pkg::LimitW-1:0] limit_q;
  logic                       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == pgb_pkg::RegGroupLimit);
  assign prdata  = reg_hit ? pgb_pkg::ApbDataW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= pgb_pkg::GroupLimitReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      limit_q <= pwdata[pgb_pkg::LimitW-1:0];
    end
  end

  // ---------------------------------------------------------- input stage
  logic             in_valid_q;
  pgb_pkg::coord_t  word_q;
  logic             last_q;
  logic             space;
  logic             fire;

  assign fire         = in_valid_q && space;
  assign path_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (path_i.ready) begin
      in_valid_q <= path_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (path_i.valid && path_i.ready) begin
      word_q <= path_i.path_word;
      last_q <= path_i.last_word;
    end
  end

  // ---------------------------------------------------------- path state
  pgb_pkg::pos_t   word_pos_q, word_pos_d;
  logic [2:0]      cr_q, cr_d;
  logic            ny_q, ny_d;
  logic            ins_q, ins_d;
  pgb_pkg::pos_t   spb_q, spb_d;
  pgb_pkg::box_t   sb_q, sb_d;
  logic            sbv_q, sbv_d;
  pgb_pkg::pos_t   gb_q, gb_d;
  pgb_pkg::len_t   gw_q, gw_d;
  logic [pgb_pkg::SubpathsW-1:0] gc_q, gc_d;
  pgb_pkg::box_t   gbox_q, gbox_d;

  // Command decode: integer part truncated toward zero.
  pgb_pkg::coord_t int_floor;
  logic            frac_nz;
  logic            is_move, is_line, is_bez;

  assign int_floor = word_q >>> pgb_pkg::FractionBits;
  assign frac_nz   = |(word_q & pgb_pkg::FracMask);
  assign is_move   = (int_floor == pgb_pkg::coord_t'(pgb_pkg::CmdMove)) ||
                     ((int_floor == {pgb_pkg::CoordW{1'b1}}) && frac_nz);
  assign is_line   = (int_floor == pgb_pkg::coord_t'(pgb_pkg::CmdLine));
  assign is_bez    = (int_floor == pgb_pkg::coord_t'(pgb_pkg::CmdBezier));

  // Subpath state after this word's own action, before any finish.
  logic            ins_a, ny_a, sbv_a;
  logic [2:0]      cr_a;
  pgb_pkg::pos_t   spb_a;
  pgb_pkg::box_t   sb_a;
  logic            finish_mid;

  always_comb begin
    ins_a      = ins_q;
    cr_a       = cr_q;
    ny_a       = ny_q;
    sbv_a      = sbv_q;
    spb_a      = spb_q;
    sb_a       = sb_q;
    finish_mid = 1'b0;
    if (!ins_q) begin
      if (is_move) begin
        ins_a = 1'b1;
        spb_a = word_pos_q;
        sbv_a = 1'b0;
        sb_a  = '0;
        cr_a  = pgb_pkg::CoordsPoint;
        ny_a  = 1'b0;
      end
    end else if (cr_q != '0) begin
      // Fold one coordinate into the box; a point counts once its y arrives.
      if (!ny_q) begin
        if (!sbv_q) begin
          sb_a.min_x = word_q;
          sb_a.max_x = word_q;
        end else begin
          if (word_q < sb_q.min_x) sb_a.min_x = word_q;
          if (word_q > sb_q.max_x) sb_a.max_x = word_q;
        end
      end else begin
        if (!sbv_q) begin
          sb_a.min_y = word_q;
          sb_a.max_y = word_q;
          sbv_a      = 1'b1;
        end else begin
          if (word_q < sb_q.min_y) sb_a.min_y = word_q;
          if (word_q > sb_q.max_y) sb_a.max_y = word_q;
        end
      end
      ny_a = !ny_q;
      cr_a = cr_q - 3'd1;
    end else if (is_move && !last_q) begin
      finish_mid = 1'b1;
    end else begin
      ny_a = 1'b0;
      if (is_move || is_line) begin
        cr_a = pgb_pkg::CoordsPoint;
      end else if (is_bez) begin
        cr_a = pgb_pkg::CoordsBezier;
      end else begin
        cr_a = '0;
      end
    end
  end

  // Finish the subpath against the current group.
  logic            finish_en;
  pgb_pkg::pos_t   fin_end, len_raw, pos_inc;
  pgb_pkg::len_t   len_full;
  pgb_pkg::box_t   sb_eff;
  logic            overlap, over_limit, emit_a, take;
  logic [pgb_pkg::LenW:0] word_sum;

  pgb_pkg::pos_t   gb_f;
  pgb_pkg::len_t   gw_f;
  logic [pgb_pkg::SubpathsW-1:0] gc_f;
  pgb_pkg::box_t   gbox_f;
  logic            emit_b;

  assign pos_inc    = word_pos_q + pgb_pkg::pos_t'(1);
  assign finish_en  = finish_mid || (last_q && ins_a);
  assign fin_end    = last_q ? pos_inc : word_pos_q;
  assign len_raw    = fin_end - spb_a;
  assign len_full   = (len_raw == '0) ? pgb_pkg::len_t'(1) << pgb_pkg::IndexBits
                                      : pgb_pkg::len_t'(len_raw);
  assign sb_eff     = sbv_a ? sb_a : '0;
  assign overlap    = (sb_eff.max_x >= gbox_q.min_x) && (sb_eff.min_x <= gbox_q.max_x) &&
                      (sb_eff.max_y >= gbox_q.min_y) && (sb_eff.min_y <= gbox_q.max_y);
  assign word_sum   = {1'b0, gw_q} + {1'b0, len_full};
  assign over_limit = word_sum > (pgb_pkg::LenW + 1)'(limit_q);
  assign take       = (gw_q == '0) || !overlap || over_limit;
  assign emit_a     = finish_en && (gw_q != '0) && (!overlap || over_limit);

  always_comb begin
    gb_f   = gb_q;
    gw_f   = gw_q;
    gc_f   = gc_q;
    gbox_f = gbox_q;
    if (finish_en) begin
      if (take) begin
        gb_f   = spb_a;
        gw_f   = len_full;
        gc_f   = pgb_pkg::SubpathsW'(1);
        gbox_f = sb_eff;
      end else begin
        gw_f = word_sum[pgb_pkg::LenW-1:0];
        if (gc_q != '1) gc_f = gc_q + pgb_pkg::SubpathsW'(1);
        if (sb_eff.min_x < gbox_q.min_x) gbox_f.min_x = sb_eff.min_x;
        if (sb_eff.min_y < gbox_q.min_y) gbox_f.min_y = sb_eff.min_y;
        if (sb_eff.max_x > gbox_q.max_x) gbox_f.max_x = sb_eff.max_x;
        if (sb_eff.max_y > gbox_q.max_y) gbox_f.max_y = sb_eff.max_y;
      end
    end
  end

  assign emit_b = last_q && (gw_f != '0);

  // Next state: end of path clears everything, a mid-path move reopens.
  always_comb begin
    word_pos_d = pos_inc;
    ins_d      = finish_en ? 1'b0 : ins_a;
    cr_d       = cr_a;
    ny_d       = ny_a;
    spb_d      = spb_a;
    sb_d       = sb_a;
    sbv_d      = sbv_a;
    gb_d       = gb_f;
    gw_d       = gw_f;
    gc_d       = gc_f;
    gbox_d     = gbox_f;
    if (finish_mid) begin
      ins_d = 1'b1;
      spb_d = word_pos_q;
      sbv_d = 1'b0;
      sb_d  = '0;
      cr_d  = pgb_pkg::CoordsPoint;
      ny_d  = 1'b0;
    end
    if (last_q) begin
      word_pos_d = '0;
      ins_d      = 1'b0;
      cr_d       = '0;
      ny_d       = 1'b0;
      spb_d      = '0;
      sb_d       = '0;
      sbv_d      = 1'b0;
      gb_d       = '0;
      gw_d       = '0;
      gc_d       = '0;
      gbox_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_pos_q <= '0;
      cr_q       <= '0;
      ny_q       <= 1'b0;
      ins_q      <= 1'b0;
      spb_q      <= '0;
      sb_q       <= '0;
      sbv_q      <= 1'b0;
      gb_q       <= '0;
      gw_q       <= '0;
      gc_q       <= '0;
      gbox_q     <= '0;
    end else if (fire) begin
      word_pos_q <= word_pos_d;
      cr_q       <= cr_d;
      ny_q       <= ny_d;
      ins_q      <= ins_d;
      spb_q      <= spb_d;
      sb_q       <= sb_d;
      sbv_q      <= sbv_d;
      gb_q       <= gb_d;
      gw_q       <= gw_d;
      gc_q       <= gc_d;
      gbox_q     <= gbox_d;
    end
  end

  // ---------------------------------------------------------- results
  pgb_pkg::result_t             res_a, res_b;
  pgb_pkg::result_slot_t [1:0]  slots;
  pgb_pkg::result_t             head;

  always_comb begin
    res_a.group_start    = pgb_pkg::StartW'(gb_q);
    res_a.group_length   = pgb_pkg::LengthW'(gw_q);
    res_a.group_subpaths = gc_q;
    res_a.flush_reason   = overlap ? pgb_pkg::ReasonLimit : pgb_pkg::ReasonDisjoint;
    res_a.last_in_run    = !emit_b;

    res_b.group_start    = pgb_pkg::StartW'(gb_f);
    res_b.group_length   = pgb_pkg::LengthW'(gw_f);
    res_b.group_subpaths = gc_f;
    res_b.flush_reason   = pgb_pkg::ReasonEnd;
    res_b.last_in_run    = 1'b1;

    // Keep results in order: slot 0 goes out first.
    slots[0].valid = fire && (emit_a || emit_b);
    slots[0].data  = emit_a ? res_a : res_b;
    slots[1].valid = fire && emit_a && emit_b;
    slots[1].data  = res_b;
  end

  pgb_result_fifo u_result_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .slots_i  (slots),
    .space_o  (space),
    .valid_o  (group_o.valid),
    .ready_i  (group_o.ready),
    .result_o (head)
  );

  assign group_o.group_start    = head.group_start;
  assign group_o.group_length   = head.group_length;
  assign group_o.group_subpaths = head.group_subpaths;
  assign group_o.flush_reason   = head.flush_reason;
  assign group_o.last_in_run    = head.last_in_run;

  // ---------------------------------------------------------- checks
  a_path_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_q) |=> (word_pos_q == '0 && !ins_q && gw_q == '0))
    else $error("path state not cleared after final word");

  a_group_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gw_q != '0) == (gc_q != '0))
    else $error("group word count and subpath count disagree");

  a_idle_no_coords : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ins_q |-> (cr_q == '0))
    else $error("coordinates owed outside a subpath");

endmodule

`default_nettype wire

### tb/tb_path_subpath_bbox_grouper_core.sv
// Testbench for the subpath bounding-box grouper: directed table, then random paths.
`timescale 1ns / 100ps

module tb_path_subpath_bbox_grouper_core;
  import pgb_pkg::*;

  localparam int MaxGap      = 15;
  localparam int DrainCycles = 8;
  localparam int QuietLimit  = 1000;
  localparam int TableRows   = 26;

  localparam logic [ApbAddrW-1:0] LimitAddr = ApbAddrW'(4 * int'(RegGroupLimit));

  // One path word as sent, plus an optional hand-written expectation.
  typedef struct {
    logic [31:0] word;
    logic        last;
    bit          known;
    int          n_known;
    result_t     known_group;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  pgb_in_if  path_if ();
  pgb_out_if group_if ();

  path_subpath_bbox_grouper_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .path_i  (path_if),
    .group_o (group_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Grouping predictor: mirrors the block's path state word by word.
  // Box arrays hold min x, min y, max x, max y in that order.
  // ---------------------------------------------------------------------------
  logic [LimitW-1:0]    limit_reg;
  pos_t                 wpos;
  logic [2:0]           owed;
  logic                 want_y;
  logic                 open_sp;
  pos_t                 sp_begin;
  int                   sp_box [4];
  logic                 sp_box_ok;
  pos_t                 grp_begin;
  len_t                 grp_words;
  logic [SubpathsW-1:0] grp_count;
  int                   grp_box [4];

  result_t groups_from_word [$];  // groups released by the word just taken
  result_t pending_groups [$];    // groups still owed by the block, oldest first

  int  mismatches;
  int  words_in;
  int  groups_out;
  int  paths_sent;
  int  limit_settings;
  int  quiet_cycles;
  int  out_hold;
  bit  idle_in;
  bit  idle_out;

  function automatic void clear_path();
    wpos      = '0;
    owed      = '0;
    want_y    = 1'b0;
    open_sp   = 1'b0;
    sp_begin  = '0;
    sp_box    = '{default: 0};
    sp_box_ok = 1'b0;
    grp_begin = '0;
    grp_words = '0;
    grp_count = '0;
    grp_box   = '{default: 0};
  endfunction

  function automatic void emit_group(reason_e why);
    result_t g;
    g.group_start    = grp_begin;
    g.group_length   = grp_words;
    g.group_subpaths = grp_count;
    g.flush_reason   = why;
    g.last_in_run    = 1'b0;
    groups_from_word.push_back(g);
  endfunction

  function automatic void open_subpath(pos_t at);
    open_sp   = 1'b1;
    sp_begin  = at;
    sp_box_ok = 1'b0;
    sp_box    = '{default: 0};
    owed      = CoordsPoint;
    want_y    = 1'b0;
  endfunction

  function automatic void take_group(len_t len, int b [4]);
    grp_begin = sp_begin;
    grp_words = len;
    grp_count = 1;
    grp_box   = b;
  endfunction

  // Close the open subpath at offset endp and fold it into the group.
  function automatic void finish_subpath(pos_t endp);
    len_t len;
    int   b [4];
    bit   ov;
    len = len_t'(pos_t'(endp - sp_begin));
    if (len == '0) len = len_t'(1) << IndexBits;  // full wrap counts as 2^IndexBits
    if (sp_box_ok) b = sp_box;
    else b = '{default: 0};
    if (grp_words == '0) begin
      take_group(len, b);
    end else begin
      ov = b[2] >= grp_box[0] && b[0] <= grp_box[2] &&
           b[3] >= grp_box[1] && b[1] <= grp_box[3];
      if (!ov || (int'(grp_words) + int'(len)) > int'(limit_reg)) begin
        emit_group(ov ? ReasonLimit : ReasonDisjoint);
        take_group(len, b);
      end else begin
        grp_words = grp_words + len;
        if (grp_count != '1) grp_count = grp_count + 1'b1;
        if (b[0] < grp_box[0]) grp_box[0] = b[0];
        if (b[1] < grp_box[1]) grp_box[1] = b[1];
        if (b[2] > grp_box[2]) grp_box[2] = b[2];
        if (b[3] > grp_box[3]) grp_box[3] = b[3];
      end
    end
    open_sp = 1'b0;
  endfunction

  // Advance the path state by one accepted word; results land in groups_from_word.
  function automatic void advance_path(logic [31:0] w, logic last);
    longint sv;
    int     cmd;
    int     c;
    pos_t   p;
    sv = longint'($signed(w));
    // Integer part truncated toward zero.
    if (sv < 0) cmd = -int'((-sv) >>> FractionBits);
    else cmd = int'(sv >>> FractionBits);
    c = int'($signed(w));
    p = wpos;
    groups_from_word.delete();

    if (!open_sp) begin
      if (cmd == CmdMove) open_subpath(p);
    end else if (owed != '0) begin
      if (!want_y) begin
        if (!sp_box_ok) begin
          sp_box[0] = c;
          sp_box[2] = c;
        end else begin
          if (c < sp_box[0]) sp_box[0] = c;
          if (c > sp_box[2]) sp_box[2] = c;
        end
      end else begin
        if (!sp_box_ok) begin
          sp_box[1] = c;
          sp_box[3] = c;
          sp_box_ok = 1'b1;
        end else begin
          if (c < sp_box[1]) sp_box[1] = c;
          if (c > sp_box[3]) sp_box[3] = c;
        end
      end
      want_y = !want_y;
      owed   = owed - 1'b1;
    end else if (cmd == CmdMove && !last) begin
      finish_subpath(p);
      open_subpath(p);
    end else begin
      // A move on the last word falls here too and only opens a truncated command.
      want_y = 1'b0;
      if (cmd == CmdMove || cmd == CmdLine) owed = CoordsPoint;
      else if (cmd == CmdBezier) owed = CoordsBezier;
      else owed = '0;
    end

    wpos = p + 1'b1;

    if (last) begin
      if (open_sp) finish_subpath(p + 1'b1);
      if (grp_words != '0) emit_group(ReasonEnd);
      clear_path();
    end

    if (groups_from_word.size() > 0) groups_from_word[$].last_in_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] fx(int v);
    return 32'(v) << FractionBits;
  endfunction

  function automatic logic [31:0] cmd_word(int cmd);
    return fx(cmd) | 32'($urandom_range(0, 65535));
  endfunction

  // Any word whose integer part truncates to zero.
  function automatic logic [31:0] move_word();
    logic [31:0] w;
    w = 32'($urandom_range(0, 65535));
    if ($urandom_range(0, 1) == 1) w = -w;
    return w;
  endfunction

  function automatic logic [31:0] unknown_word();
    logic [31:0] w;
    if ($urandom_range(0, 1) == 0) return cmd_word($urandom_range(4, 32767));
    w = $urandom | 32'h8000_0000;
    if (w > 32'hFFFF_0000) w = 32'hFFFF_0000;  // keep the magnitude at one or more
    return w;
  endfunction

  function automatic logic [31:0] coord_near(int base, int spread);
    case ($urandom_range(0, 31))
      0:       return $urandom;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      default: return fx(base + $urandom_range(0, spread)) | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic stim_row_t step_row(logic [31:0] w, logic last);
    stim_row_t r;
    r.word        = w;
    r.last        = last;
    r.known       = 1'b0;
    r.n_known     = 0;
    r.known_group = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [31:0] w, logic last, int n, int start,
                                         int length, int subpaths, reason_e why);
    stim_row_t r;
    r = step_row(w, last);
    r.known                      = 1'b1;
    r.n_known                    = n;
    r.known_group.group_start    = StartW'(start);
    r.known_group.group_length   = LengthW'(length);
    r.known_group.group_subpaths = SubpathsW'(subpaths);
    r.known_group.flush_reason   = why;
    r.known_group.last_in_run    = 1'b1;
    return r;
  endfunction

  // Append n coordinates, alternating x and y around a subpath center.
  function automatic void add_coords(ref stim_row_t q [$], input int n, input int cx,
                                     input int cy, input int spread);
    for (int i = 0; i < n; i++)
      q.push_back(step_row(coord_near((i % 2 == 0) ? cx : cy, spread), 1'b0));
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and the result side
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold ready low for the drawn number of cycles after each result transfer.
  initial begin
    group_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_hold > 0) begin
        group_if.ready <= 1'b0;
        out_hold--;
      end else begin
        group_if.ready <= 1'b1;
      end
    end
  end

  // Check every result transfer against the oldest pending group.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && group_if.valid === 1'b1 && group_if.ready === 1'b1) begin
      groups_out++;
      out_hold = idle_out ? $urandom_range(0, MaxGap) : 0;
      if (pending_groups.size() == 0) begin
        $display("%0t: group result with nothing expected: start %0d length %0d",
                 $time, group_if.group_start, group_if.group_length);
        mismatches++;
      end else begin
        want = pending_groups.pop_front();
        check_field("group_start", want.group_start, group_if.group_start);
        check_field("group_length", want.group_length, group_if.group_length);
        check_field("group_subpaths", want.group_subpaths, group_if.group_subpaths);
        check_field("flush_reason", want.flush_reason, group_if.flush_reason);
        check_field("last_in_run", want.last_in_run, group_if.last_in_run);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((path_if.valid === 1'b1 && path_if.ready === 1'b1) ||
        (group_if.valid === 1'b1 && group_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d groups still pending",
                 $time, quiet_cycles, pending_groups.size());
        $display("tb_path_subpath_bbox_grouper_core: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one path word after a drawn gap, then book the groups it releases.
  task automatic push_word(input stim_row_t row);
    int gap;
    gap = idle_in ? $urandom_range(0, MaxGap) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      path_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    path_if.valid     <= 1'b1;
    path_if.path_word <= row.word;
    path_if.last_word <= row.last;
    do @(posedge clk_i); while (!(path_if.valid === 1'b1 && path_if.ready === 1'b1));
    words_in++;
    advance_path(row.word, row.last);
    if (row.known) begin
      for (int i = 0; i < row.n_known; i++) pending_groups.push_back(row.known_group);
    end else begin
      foreach (groups_from_word[i]) pending_groups.push_back(groups_from_word[i]);
    end
  endtask

  // Drop valid, wait for every pending group, then give in-flight words time to land.
  task automatic settle();
    @(negedge clk_i);
    path_if.valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register transfer: setup cycle, then access until pready.
  task automatic apb_cycle(input logic wr, input logic [ApbDataW-1:0] wdata,
                           output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LimitAddr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limit(input logic [LimitW-1:0] value);
    logic [ApbDataW-1:0] rd;
    apb_cycle(1'b1, ApbDataW'(value), rd);
    apb_cycle(1'b0, '0, rd);
    check_field("group_word_limit readback", ApbDataW'(value), rd);
    limit_reg = value;
    limit_settings++;
  endtask

  // Random paths: mostly well-formed subpaths with random content, some junk and damage.
  task automatic run_random_paths(input int target_words);
    stim_row_t path_rows [$];
    int        sent;
    int        cx;
    int        cy;
    int        spread;
    int        cut;
    sent = 0;
    while (sent < target_words) begin
      path_rows.delete();
      // Leading junk ahead of the first move.
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) path_rows.push_back(step_row($urandom, 1'b0));
      repeat ($urandom_range(1, 5)) begin
        cx     = $urandom_range(0, 400) - 200;
        cy     = $urandom_range(0, 400) - 200;
        spread = $urandom_range(0, 60);
        path_rows.push_back(step_row(move_word(), 1'b0));
        add_coords(path_rows, 2, cx, cy, spread);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 4))
            0, 1: begin
              path_rows.push_back(step_row(cmd_word(CmdLine), 1'b0));
              add_coords(path_rows, 2, cx, cy, spread);
            end
            2: begin
              path_rows.push_back(step_row(cmd_word(CmdBezier), 1'b0));
              add_coords(path_rows, 6, cx, cy, spread);
            end
            3:       path_rows.push_back(step_row(cmd_word(CmdClose), 1'b0));
            default: path_rows.push_back(step_row(unknown_word(), 1'b0));
          endcase
        end
      end
      // Pick how the path ends.
      case ($urandom_range(0, 3))
        0: path_rows[$].last = 1'b1;
        1: begin
          // Truncated command: fewer coordinates than owed.
          if ($urandom_range(0, 1) == 0) begin
            path_rows.push_back(step_row(cmd_word(CmdLine), 1'b0));
            cut = $urandom_range(0, 1);
          end else begin
            path_rows.push_back(step_row(cmd_word(CmdBezier), 1'b0));
            cut = $urandom_range(0, 5);
          end
          add_coords(path_rows, cut, cx, cy, spread);
          path_rows[$].last = 1'b1;
        end
        2:       path_rows.push_back(step_row(move_word(), 1'b1));
        default: path_rows.push_back(step_row($urandom, 1'b1));
      endcase
      // Damage one word now and then to break the sequence.
      if ($urandom_range(0, 7) == 0)
        path_rows[$urandom_range(0, path_rows.size() - 1)].word = $urandom;
      foreach (path_rows[i]) push_word(path_rows[i]);
      sent += path_rows.size();
      paths_sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [TableRows];

  initial begin
    logic [ApbDataW-1:0] rd;

    rst_ni            = 1'b0;
    path_if.valid     = 1'b0;
    path_if.path_word = '0;
    path_if.last_word = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mismatches        = 0;
    words_in          = 0;
    groups_out        = 0;
    paths_sent        = 0;
    limit_settings    = 0;
    quiet_cycles      = 0;
    out_hold          = 0;
    idle_in           = 1'b1;
    idle_out          = 1'b1;
    limit_reg         = GroupLimitReset;
    clear_path();

    directed_rows = '{
      // No move yet: all skipped, and the path ends with nothing to emit.
      step_row(fx(CmdLine), 1'b0),
      known_row(32'h8000_0000, 1'b1, 0, 0, 0, 0, ReasonEnd),
      // One subpath with extreme coordinates, closed on the last word.
      step_row(fx(CmdMove), 1'b0),
      step_row(32'h7FFF_FFFF, 1'b0),
      step_row(32'h8000_0000, 1'b0),
      known_row(fx(CmdClose), 1'b1, 1, 0, 4, 1, ReasonEnd),
      // Move with a full fraction, then a bezier and a negative unknown command.
      step_row(32'h0000_FFFF, 1'b0),
      step_row(fx(10), 1'b0),
      step_row(fx(10), 1'b0),
      step_row(fx(CmdBezier), 1'b0),
      step_row(fx(12), 1'b0),
      step_row(fx(14) | 32'h0000_8000, 1'b0),
      step_row(fx(20), 1'b0),
      step_row(fx(11), 1'b0),
      step_row(fx(15), 1'b0),
      step_row(fx(20), 1'b0),
      step_row(32'hFFFE_0000, 1'b0),
      // Negative word that truncates to a move: second, disjoint subpath.
      step_row(32'hFFFF_0001, 1'b0),
      step_row(fx(-1000), 1'b0),
      step_row(fx(-1000), 1'b0),
      step_row(fx(CmdLine), 1'b0),
      step_row(fx(-990), 1'b0),
      step_row(fx(-995), 1'b0),
      // Lone final move: disjoint flush plus end flush on one word.
      step_row(32'h0000_8000, 1'b1),
      // Last word cuts a move short after a lone x.
      step_row(fx(CmdMove), 1'b0),
      known_row(fx(5), 1'b1, 1, 0, 2, 1, ReasonEnd)
    };

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register must come up at its reset value.
    apb_cycle(1'b0, '0, rd);
    check_field("group_word_limit after reset", ApbDataW'(GroupLimitReset), rd);

    foreach (directed_rows[i]) push_word(directed_rows[i]);
    settle();

    // Random phases across limits, extremes included, with idling on and off.
    set_limit('1);
    run_random_paths(100);
    settle();

    set_limit(LimitW'(1));
    idle_out = 1'b0;
    run_random_paths(90);
    settle();

    set_limit('0);
    idle_in  = 1'b0;
    idle_out = 1'b1;
    run_random_paths(70);
    settle();

    set_limit(LimitW'(24));
    idle_in  = 1'b0;
    idle_out = 1'b0;
    run_random_paths(110);
    settle();

    set_limit(LimitW'($urandom_range(8, 200)));
    idle_in  = 1'b1;
    idle_out = 1'b1;
    run_random_paths(100);
    settle();

    $display("Covered %0d path words in %0d random paths plus the directed table,",
             words_in, paths_sent);
    $display("checked %0d groups over %0d limit settings; %0d mismatches.",
             groups_out, limit_settings, mismatches);
    if (mismatches == 0) begin
      $display("tb_path_subpath_bbox_grouper_core: PASS");
    end else begin
      $display("tb_path_subpath_bbox_grouper_core: FAIL");
    end
    $finish;
  end

endmodule
